@@ sv/blca_pkg.sv @@
// Package for the binary lifting LCA block: sizes, payload words, status codes,
// controller states, and the command/status structs between controller and datapath.
// No dependencies.
package blca_pkg;

  localparam int MAX_NODES = 4096;
  localparam int LEVELS    = 12;
  localparam int NODE_W    = 12;
  localparam int DEPTH_W   = NODE_W;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_AW    = NODE_W + LVL_W;
  localparam int DIFF_X_W  = 2 ** LVL_W;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic              action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] result_node;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ADD_INIT,
    S_UP_RD,
    S_UP_WR,
    S_ADD_DONE,
    S_ORDER,
    S_LIFT,
    S_LIFT_WR,
    S_MEET,
    S_DESC_RD,
    S_DESC_WR,
    S_FIN_RD,
    S_FIN_WR,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DEP_RD,
    OP_ADD_INIT,
    OP_ANC_RD,
    OP_UP_WR,
    OP_ADD_DONE,
    OP_ORDER,
    OP_LV_NEXT,
    OP_LIFT_WR,
    OP_LV_TOP,
    OP_DESC_WR,
    OP_RES_X,
    OP_RES_A,
    OP_ERR
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e sts;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic bad;
    logic full;
    logic up_last;
    logic lv_bit;
    logic lv_top;
    logic lv_zero;
    logic xy_eq;
  } dp_stat_t;

endpackage

@@ sv/blca_dp.sv @@
// Datapath of the LCA block: node registers, level counter, node count, depth
// and ancestor memories, result register. Driven by blca_ctrl. Uses blca_pkg.
module blca_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blca_pkg::in_t     item_i,
  input  blca_pkg::dp_cmd_t cmd_i,
  output blca_pkg::dp_stat_t stat_o,
  output blca_pkg::out_t    result_o
);
  import blca_pkg::*;

  logic [NODE_W-1:0]  anc_mem [2**ANC_AW];
  logic [DEPTH_W-1:0] dep_mem [MAX_NODES];

  logic [NODE_W-1:0]  x_q, x_d, y_q, y_d, res_q, res_d;
  logic [LVL_W-1:0]   lv_q, lv_d;
  logic [DEPTH_W-1:0] diff_q, diff_d;
  logic               act_q, act_d;
  status_e            sts_q, sts_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [NODE_W-1:0]  anc_rd_a_q, anc_rd_b_q;
  logic               anc_root_a_q, anc_root_b_q;
  logic [DEPTH_W-1:0] dep_rd_a_q, dep_rd_b_q;
  logic               dep_root_a_q, dep_root_b_q;

  logic [NODE_W-1:0]   anc_a, anc_b, fresh;
  logic [DEPTH_W-1:0]  dep_a, dep_b;
  logic                anc_we;
  logic [ANC_AW-1:0]   anc_waddr;
  logic [NODE_W-1:0]   anc_wdata;
  logic [DIFF_X_W-1:0] diff_ext;

  // the root never gets written: its depth and every ancestor read as zero
  assign anc_a    = anc_root_a_q ? '0 : anc_rd_a_q;
  assign anc_b    = anc_root_b_q ? '0 : anc_rd_b_q;
  assign dep_a    = dep_root_a_q ? '0 : dep_rd_a_q;
  assign dep_b    = dep_root_b_q ? '0 : dep_rd_b_q;
  assign fresh    = cnt_q[NODE_W-1:0];
  assign diff_ext = DIFF_X_W'(diff_q);

  always_comb begin
    anc_we    = 1'b0;
    anc_waddr = {fresh, lv_q + LVL_W'(1)};
    anc_wdata = anc_b;
    case (cmd_i.op)
      OP_ADD_INIT: begin
        anc_we    = 1'b1;
        anc_waddr = {fresh, LVL_W'(0)};
        anc_wdata = x_q;
      end
      OP_UP_WR: anc_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    if (cmd_i.op == OP_ADD_INIT) begin
      dep_mem[fresh] <= dep_a + DEPTH_W'(1);
    end
    if (cmd_i.op == OP_ANC_RD) begin
      anc_rd_a_q   <= anc_mem[{x_q, lv_q}];
      anc_rd_b_q   <= anc_mem[{y_q, lv_q}];
      anc_root_a_q <= (x_q == '0);
      anc_root_b_q <= (y_q == '0);
    end
    if (cmd_i.op == OP_DEP_RD) begin
      dep_rd_a_q   <= dep_mem[x_q];
      dep_rd_b_q   <= dep_mem[y_q];
      dep_root_a_q <= (x_q == '0);
      dep_root_b_q <= (y_q == '0);
    end
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    lv_d   = lv_q;
    diff_d = diff_q;
    act_d  = act_q;
    res_d  = res_q;
    sts_d  = sts_q;
    cnt_d  = cnt_q;
    case (cmd_i.op)
      OP_LATCH: begin
        act_d = item_i.action;
        // on add, x holds the parent (the smaller index)
        if (item_i.action == ACT_QUERY || item_i.node_a < item_i.node_b) begin
          x_d = item_i.node_a;
          y_d = item_i.node_b;
        end else begin
          x_d = item_i.node_b;
          y_d = item_i.node_a;
        end
      end
      OP_ADD_INIT: begin
        y_d  = x_q;
        lv_d = '0;
      end
      OP_UP_WR: begin
        y_d  = anc_b;
        lv_d = lv_q + LVL_W'(1);
      end
      OP_ADD_DONE: begin
        res_d = fresh;
        sts_d = ST_OK;
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_ORDER: begin
        lv_d = '0;
        // keep the deeper node in y
        if (dep_a > dep_b) begin
          x_d    = y_q;
          y_d    = x_q;
          diff_d = dep_a - dep_b;
        end else begin
          diff_d = dep_b - dep_a;
        end
      end
      OP_LV_NEXT: lv_d = lv_q + LVL_W'(1);
      OP_LIFT_WR: begin
        y_d  = anc_b;
        lv_d = lv_q + LVL_W'(1);
      end
      OP_LV_TOP: lv_d = LVL_W'(LEVELS - 1);
      OP_DESC_WR: begin
        if (anc_a != anc_b) begin
          x_d = anc_a;
          y_d = anc_b;
        end
        if (lv_q != '0) begin
          lv_d = lv_q - LVL_W'(1);
        end
      end
      OP_RES_X: begin
        res_d = x_q;
        sts_d = ST_OK;
      end
      OP_RES_A: begin
        res_d = anc_a;
        sts_d = ST_OK;
      end
      OP_ERR: begin
        res_d = '0;
        sts_d = cmd_i.sts;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    lv_q   <= lv_d;
    diff_q <= diff_d;
    act_q  <= act_d;
    res_q  <= res_d;
    sts_q  <= sts_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(1);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    stat_o.is_add  = (act_q == ACT_ADD);
    stat_o.bad     = (CNT_W'(x_q) >= cnt_q) ||
                     ((act_q == ACT_QUERY) && (CNT_W'(y_q) >= cnt_q));
    stat_o.full    = (cnt_q >= CNT_W'(MAX_NODES));
    stat_o.up_last = (int'(lv_q) + 2 >= LEVELS);
    stat_o.lv_bit  = diff_ext[lv_q];
    stat_o.lv_top  = (lv_q == LVL_W'(LEVELS - 1));
    stat_o.lv_zero = (lv_q == '0);
    stat_o.xy_eq   = (x_q == y_q);
  end

  assign result_o.status      = sts_q;
  assign result_o.result_node = res_q;

endmodule

@@ sv/blca_ctrl.sv @@
// Controller of the LCA block: sequences adds and queries and issues datapath
// commands. Uses blca_pkg; pairs with blca_dp.
module blca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  blca_pkg::dp_stat_t stat_i,
  output blca_pkg::dp_cmd_t  cmd_o
);
  import blca_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sts  = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.bad) begin
          cmd_o.op  = OP_ERR;
          cmd_o.sts = ST_BAD_INDEX;
          state_d   = S_DONE;
        end else if (stat_i.is_add && stat_i.full) begin
          cmd_o.op  = OP_ERR;
          cmd_o.sts = ST_FULL;
          state_d   = S_DONE;
        end else begin
          cmd_o.op = OP_DEP_RD;
          state_d  = stat_i.is_add ? S_ADD_INIT : S_ORDER;
        end
      end
      S_ADD_INIT: begin
        cmd_o.op = OP_ADD_INIT;
        state_d  = (LEVELS > 1) ? S_UP_RD : S_ADD_DONE;
      end
      S_UP_RD: begin
        cmd_o.op = OP_ANC_RD;
        state_d  = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.op = OP_UP_WR;
        state_d  = stat_i.up_last ? S_ADD_DONE : S_UP_RD;
      end
      S_ADD_DONE: begin
        cmd_o.op = OP_ADD_DONE;
        state_d  = S_DONE;
      end
      S_ORDER: begin
        cmd_o.op = OP_ORDER;
        state_d  = S_LIFT;
      end
      S_LIFT: begin
        // fetch only on set bits of the depth difference
        if (stat_i.lv_bit) begin
          cmd_o.op = OP_ANC_RD;
          state_d  = S_LIFT_WR;
        end else begin
          cmd_o.op = OP_LV_NEXT;
          state_d  = stat_i.lv_top ? S_MEET : S_LIFT;
        end
      end
      S_LIFT_WR: begin
        cmd_o.op = OP_LIFT_WR;
        state_d  = stat_i.lv_top ? S_MEET : S_LIFT;
      end
      S_MEET: begin
        if (stat_i.xy_eq) begin
          cmd_o.op = OP_RES_X;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_LV_TOP;
          state_d  = S_DESC_RD;
        end
      end
      S_DESC_RD: begin
        cmd_o.op = OP_ANC_RD;
        state_d  = S_DESC_WR;
      end
      S_DESC_WR: begin
        cmd_o.op = OP_DESC_WR;
        state_d  = stat_i.lv_zero ? S_FIN_RD : S_DESC_RD;
      end
      S_FIN_RD: begin
        cmd_o.op = OP_ANC_RD;
        state_d  = S_FIN_WR;
      end
      S_FIN_WR: begin
        cmd_o.op = OP_RES_A;
        state_d  = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

@@ sv/binary_lifting_lca.sv @@
// Top level of the binary lifting LCA block: controller plus datapath.
// Depends on blca_pkg, blca_ctrl and blca_dp.
//
// Use: present a word on item_i with start high; it is taken at a clock edge
// where busy is low. action 0 adds a leaf under the smaller of node_a/node_b,
// action 1 asks for the lowest common ancestor of node_a and node_b.
// Exactly one result word per item appears on result_o for a single cycle,
// marked by done_o; the receiver cannot hold it off, so capture it then.
// busy stays high from the cycle after acceptance up to and including the
// done_o cycle; the next word can be taken the cycle after that.
// Steps from acceptance to the done_o cycle (LEVELS = 12):
//   error result (bad index or tree full): the index check, then done
//   add: parent link and depth written, then an ancestor read and write per level
//   query: a lift step per level, with an extra ancestor read on each set bit of
//   the depth difference, then read and update per level on descent unless already met
// One item is worked at a time; each level step that uses the ancestor memory is a
// registered read of that memory followed by an update of the node registers.
// Reset leaves only the root, node 0, in the tree; the memories are not
// cleared, as the root reads as zero by logic and other entries are written
// before any read can reach them.
module binary_lifting_lca (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  blca_pkg::in_t  item_i,
  output logic           done_o,
  output blca_pkg::out_t result_o
);
  import blca_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  blca_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  blca_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

endmodule

@@ sv/blca_checker.sv @@
// Port-level checker for binary_lifting_lca, attached by the bind at the end.
// Uses blca_pkg.
module blca_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input blca_pkg::out_t result_o
);
  import blca_pkg::*;

  // a result only ever closes a busy period
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("done without busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result word repeated or busy held");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(done_o))
    else $error("busy dropped without a result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status != ST_OK) |-> (result_o.result_node == '0))
    else $error("error result carries a node");

endmodule

bind binary_lifting_lca blca_checker u_blca_checker (.*);

@@ sim/binary_lifting_lca_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binary_lifting_lca: directed and random add and query words,
// predicted on the fly by a behavioural copy of the tree. Depends on blca_pkg.
module binary_lifting_lca_test;
  import blca_pkg::*;

  typedef struct {
    in_t         word;
    int unsigned idle_pct;
  } backlog_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  item_q = '0;
  logic busy;
  logic done_o;
  out_t result_o;

  binary_lifting_lca u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_q),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Expected tree, updated as each word is accepted
  logic [NODE_W-1:0] anc_tab [MAX_NODES][LEVELS];
  logic [NODE_W-1:0] node_dep [MAX_NODES];
  int unsigned       tree_size = 1;

  backlog_t    cmd_backlog [$];
  out_t        pending_results [$];
  int unsigned shadow_size = 1;   // node count as seen while generating words
  int unsigned phase_pct [3] = '{0, 67, 34};
  int unsigned n_queued, n_accepted, fail_count;
  int unsigned n_added, n_asked, n_bad, n_full;
  logic        taken = 1'b0;

  function automatic out_t lca_predict(in_t w);
    out_t              r;
    int unsigned       p;
    logic [NODE_W-1:0] x, y, t;
    logic [LEVELS-1:0] gap;
    r = '0;
    if (w.action == ACT_ADD) begin
      p = 32'((w.node_a < w.node_b) ? w.node_a : w.node_b);
      if (p >= tree_size) begin
        r.status = ST_BAD_INDEX;
      end else if (tree_size >= MAX_NODES) begin
        r.status = ST_FULL;
      end else begin
        node_dep[tree_size] = node_dep[p] + NODE_W'(1);
        anc_tab[tree_size][0] = p[NODE_W-1:0];
        for (int lv = 1; lv < LEVELS; lv++)
          anc_tab[tree_size][lv] = anc_tab[anc_tab[tree_size][lv-1]][lv-1];
        r.result_node = tree_size[NODE_W-1:0];
        tree_size++;
      end
    end else if (w.node_a >= tree_size || w.node_b >= tree_size) begin
      r.status = ST_BAD_INDEX;
    end else begin
      x = w.node_a;
      y = w.node_b;
      if (node_dep[x] > node_dep[y]) begin
        t = x;
        x = y;
        y = t;
      end
      // lift the deeper node by 2**lv levels for each set bit lv of the depth gap
      gap = LEVELS'(node_dep[y] - node_dep[x]);
      for (int lv = 0; lv < LEVELS; lv++)
        if (gap[lv]) y = anc_tab[y][lv];
      if (x == y) begin
        r.result_node = x;
      end else begin
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
          if (anc_tab[x][lv] != anc_tab[y][lv]) begin
            x = anc_tab[x][lv];
            y = anc_tab[y][lv];
          end
        end
        r.result_node = anc_tab[x][0];
      end
    end
    return r;
  endfunction

  function automatic void push_word(logic act, int unsigned a, int unsigned b,
                                    int unsigned pct);
    backlog_t e;
    int unsigned p;
    e.word.action = act;
    e.word.node_a = a[NODE_W-1:0];
    e.word.node_b = b[NODE_W-1:0];
    e.idle_pct    = pct;
    cmd_backlog.insert(cmd_backlog.size(), e);
    p = (a < b) ? a : b;
    if (act == ACT_ADD && p < shadow_size && shadow_size < MAX_NODES) shadow_size++;
  endfunction

  // Bias towards recent nodes so the tree grows deep
  function automatic int unsigned pick_node();
    case ($urandom_range(3))
      0:       return shadow_size - 1;
      1:       return (shadow_size > 8) ? $urandom_range(shadow_size - 1, shadow_size - 8)
                                        : $urandom_range(shadow_size - 1);
      default: return $urandom_range(shadow_size - 1);
    endcase
  endfunction

  function automatic void push_add(int unsigned p, int unsigned pct);
    int unsigned other;
    other = $urandom_range(MAX_NODES - 1, p);
    if ($urandom_range(1)) push_word(ACT_ADD, p, other, pct);
    else push_word(ACT_ADD, other, p, pct);
  endfunction

  function automatic void push_query(int unsigned pct);
    int unsigned a, b;
    a = pick_node();
    b = ($urandom_range(9) == 0) ? a : $urandom_range(shadow_size - 1);
    if ($urandom_range(1)) push_word(ACT_QUERY, a, b, pct);
    else push_word(ACT_QUERY, b, a, pct);
  endfunction

  function automatic void push_bad(int unsigned pct);
    int unsigned a, b;
    if (shadow_size >= MAX_NODES) begin
      push_query(pct);
    end else if ($urandom_range(1)) begin
      push_add($urandom_range(MAX_NODES - 1, shadow_size), pct);
    end else begin
      a = $urandom_range(MAX_NODES - 1, shadow_size);
      b = $urandom_range(MAX_NODES - 1);
      if ($urandom_range(1)) push_word(ACT_QUERY, a, b, pct);
      else push_word(ACT_QUERY, b, a, pct);
    end
  endfunction

  // Driver: offer the next word once the current one is taken, idling at random
  always @(negedge clk_i) begin : driver
    backlog_t nxt;
    if (rst_ni && (!start || taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
        nxt    = cmd_backlog.pop_front();
        start  <= 1'b1;
        item_q <= nxt.word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on acceptance, check each result word against the oldest prediction
  always @(posedge clk_i) begin : monitor
    out_t want;
    taken <= start && !busy;
    if (rst_ni && start && !busy) begin
      want = lca_predict(item_q);
      pending_results.insert(pending_results.size(), want);
      n_accepted++;
      case (want.status)
        ST_BAD_INDEX: n_bad++;
        ST_FULL:      n_full++;
        default:      if (item_q.action == ACT_ADD) n_added++; else n_asked++;
      endcase
    end
    if (done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result word with nothing pending: status %0d node %0d",
                   $realtime, result_o.status, result_o.result_node);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.result_node !== want.result_node) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch: status %0d node %0d, expected status %0d node %0d",
                     $realtime, result_o.status, result_o.result_node,
                     want.status, want.result_node);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pct, i, r, deepest;
    for (int lv = 0; lv < LEVELS; lv++) anc_tab[0][lv] = '0;
    node_dep[0] = '0;

    // Directed: root only, small tree, equal fields, unchecked larger field, bad indices
    push_word(ACT_QUERY, 0, 0, 0);
    push_word(ACT_ADD, 0, MAX_NODES - 1, 0);
    push_word(ACT_ADD, MAX_NODES - 1, 1, 0);
    push_word(ACT_ADD, 1, 1, 0);
    push_word(ACT_ADD, 0, 0, 0);
    push_word(ACT_ADD, 2, 3, 0);
    push_word(ACT_ADD, 6, 7, 0);
    push_word(ACT_ADD, MAX_NODES - 1, MAX_NODES - 1, 0);
    push_word(ACT_QUERY, 3, 2, 0);
    push_word(ACT_QUERY, 2, 4, 0);
    push_word(ACT_QUERY, 4, 4, 0);
    push_word(ACT_QUERY, 1, 5, 0);
    push_word(ACT_QUERY, 5, 1, 0);
    push_word(ACT_QUERY, 0, 5, 0);
    push_word(ACT_QUERY, 5, 4, 0);
    push_word(ACT_QUERY, 6, 0, 0);
    push_word(ACT_QUERY, 0, MAX_NODES - 1, 0);
    push_word(ACT_QUERY, MAX_NODES - 1, MAX_NODES - 1, 0);
    push_word(ACT_QUERY, 3, 6, 0);

    // Random mix, idling changed every 200 words
    for (i = 0; i < 1500; i++) begin
      pct = phase_pct[(i / 200) % 3];
      r = $urandom_range(99);
      if (r < 45) push_add(pick_node(), pct);
      else if (r < 55) push_bad(pct);
      else push_query(pct);
    end

    // Extend one long chain from the newest node, with queries sprinkled in
    for (int k = 0; k < 100; k++) begin
      if (k % 8 == 0) push_query(phase_pct[k % 3]);
      else push_add(shadow_size - 1, phase_pct[k % 3]);
    end
    n_queued = cmd_backlog.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_accepted == n_queued && pending_results.size() == 0)) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("%0d result words never arrived", pending_results.size());
    end
    deepest = 0;
    for (int n = 0; n < tree_size; n++)
      if (node_dep[n] > deepest) deepest = 32'(node_dep[n]);
    $display("Ran %0d words: %0d leaves added, %0d ancestor queries answered,",
             n_accepted, n_added, n_asked);
    $display("%0d bad-index and %0d full rejections; deepest node at depth %0d.",
             n_bad, n_full, deepest);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
